// ===== sv/cprm_pkg.sv =====
// ----------------------------------------------------------------------------
// cprm_pkg
// Shared types and constants for the capture-period rpm meter.
// ----------------------------------------------------------------------------
package cprm_pkg;

   localparam int TIMER_BITS  = 16;
   localparam int OVF_BITS    = 16;
   localparam int DATA_BITS   = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int STEP_BITS   = $clog2(DATA_BITS);

   localparam logic [DATA_BITS-1:0] RPM_SCALE_RESET = DATA_BITS'(15000000);
   localparam logic [STEP_BITS-1:0] LAST_STEP       = STEP_BITS'(DATA_BITS - 1);

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIVIDE,
      BACK_DONE
   } back_state_type;

endpackage

// ===== sv/cprm_front.sv =====
// ----------------------------------------------------------------------------
// cprm_front
// Tick-driven timer, overflow count and edge capture; emits one period per
// capture edge into the queue.
// ----------------------------------------------------------------------------
module cprm_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           tick_accept,
   input  logic                           edge_req,
   output logic                           q_write,
   output logic [cprm_pkg::DATA_BITS-1:0] q_period
);
   import cprm_pkg::*;

   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [OVF_BITS-1:0]   ovf_ff, ovf_in;
   logic [TIMER_BITS-1:0] last_ff, last_in;
   logic [TIMER_BITS-1:0] prev_ff, prev_in;
   logic [DATA_BITS-1:0]  base;
   logic [DATA_BITS-1:0]  diff;
   logic                  take_edge;
   logic                  wrap;

   assign take_edge = tick_accept & edge_req;
   assign wrap      = (timer_ff == {TIMER_BITS{1'b1}});

   // Difference wraps modulo 2^32, as a negative value would
   assign base = DATA_BITS'(ovf_ff) << TIMER_BITS;
   assign diff = DATA_BITS'(timer_ff) - DATA_BITS'(last_ff);

   assign q_write  = take_edge;
   assign q_period = base + diff;

   always_comb begin
      timer_in = timer_ff;
      ovf_in   = ovf_ff;
      last_in  = last_ff;
      prev_in  = prev_ff;
      if (tick_accept) begin
         timer_in = timer_ff + TIMER_BITS'(1);
         if (take_edge) begin
            prev_in = last_ff;
            last_in = timer_ff;
            ovf_in  = '0;
         end
         // Count the wrap after the edge clears the count
         if (wrap) begin
            ovf_in = (take_edge ? OVF_BITS'(0) : ovf_ff) + OVF_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
         ovf_ff   <= '0;
         last_ff  <= '0;
         prev_ff  <= '0;
      end else begin
         timer_ff <= timer_in;
         ovf_ff   <= ovf_in;
         last_ff  <= last_in;
         prev_ff  <= prev_in;
      end
   end

endmodule

// ===== sv/cprm_queue.sv =====
// ----------------------------------------------------------------------------
// cprm_queue
// Short queue of periods between the capture front and the divider.
// ----------------------------------------------------------------------------
module cprm_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [cprm_pkg::DATA_BITS-1:0] wr_data,
   input  logic                           rd_en,
   output logic [cprm_pkg::DATA_BITS-1:0] rd_data,
   output cprm_pkg::queue_status_type     status
);
   import cprm_pkg::*;

   logic [DATA_BITS-1:0] slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wptr_ff, wptr_in;
   logic [QPTR_BITS-1:0] rptr_ff, rptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_wr;
   logic                 do_rd;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign do_wr        = wr_en & ~status.full;
   assign do_rd        = rd_en & ~status.empty;
   assign rd_data      = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_wr ? wptr_ff + QPTR_BITS'(1) : wptr_ff;
      rptr_in  = do_rd ? rptr_ff + QPTR_BITS'(1) : rptr_ff;
      count_in = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/cprm_divider.sv =====
// ----------------------------------------------------------------------------
// cprm_divider
// Radix-2 restoring divider: rpm = scale / period, one quotient bit a cycle,
// and the result register on the output side.
// ----------------------------------------------------------------------------
module cprm_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [cprm_pkg::DATA_BITS-1:0] csr_write_data,
   input  cprm_pkg::queue_status_type     q_status,
   input  logic [cprm_pkg::DATA_BITS-1:0] q_period,
   output logic                           q_read,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [cprm_pkg::DATA_BITS-1:0] rsp_period_ticks,
   output logic [cprm_pkg::DATA_BITS-1:0] rsp_rpm,
   output logic                           rsp_valid_res
);
   import cprm_pkg::*;

   back_state_type       state_ff, state_in;
   logic [DATA_BITS-1:0] scale_ff, scale_in;
   logic [DATA_BITS-1:0] rem_ff, rem_in;
   logic [DATA_BITS-1:0] dvd_ff, dvd_in;
   logic [DATA_BITS-1:0] den_ff, den_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic                 valid_ff, valid_in;
   logic [DATA_BITS:0]   trial;
   logic [DATA_BITS:0]   trial_sub;
   logic                 fits;
   logic                 zero_period;

   assign zero_period = (q_period == '0);
   assign trial       = {rem_ff, dvd_ff[DATA_BITS-1]};
   assign trial_sub   = trial - {1'b0, den_ff};
   assign fits        = ~trial_sub[DATA_BITS];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!q_status.empty) begin
               state_in = zero_period ? BACK_DONE : BACK_DIVIDE;
            end
         end
         BACK_DIVIDE: begin
            if (step_ff == LAST_STEP) begin
               state_in = BACK_DONE;
            end
         end
         BACK_DONE: begin
            if (rsp_pop) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      q_read    = (state_ff == BACK_IDLE) && !q_status.empty;
      rsp_empty = (state_ff != BACK_DONE);
   end

   always_comb begin
      scale_in = csr_write_en ? csr_write_data : scale_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      den_in   = den_ff;
      step_in  = step_ff;
      valid_in = valid_ff;
      if (q_read) begin
         // Zero period: saturate the rate and flag it
         rem_in   = '0;
         dvd_in   = zero_period ? {DATA_BITS{1'b1}} : scale_ff;
         den_in   = q_period;
         step_in  = '0;
         valid_in = ~zero_period;
      end else if (state_ff == BACK_DIVIDE) begin
         rem_in  = fits ? trial_sub[DATA_BITS-1:0] : trial[DATA_BITS-1:0];
         dvd_in  = {dvd_ff[DATA_BITS-2:0], fits};
         step_in = step_ff + STEP_BITS'(1);
      end
   end

   assign rsp_period_ticks = den_ff;
   assign rsp_rpm          = dvd_ff;
   assign rsp_valid_res    = valid_ff;

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
      den_ff   <= den_in;
      step_ff  <= step_in;
      valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         scale_ff <= RPM_SCALE_RESET;
      end else begin
         state_ff <= state_in;
         scale_ff <= scale_in;
      end
   end

endmodule

// ===== sv/capture_period_rpm_meter_unit.sv =====
// ----------------------------------------------------------------------------
// capture_period_rpm_meter_unit
// Input-capture tachometer: period between capture edges and rpm.
// ----------------------------------------------------------------------------
// Each accepted req_ beat is one prescaled timer tick; ticks are taken back
// to back while the period queue has room. A tick flagged with edge_req
// captures the timer and pushes the period (overflows * 2^16 plus the
// capture difference, modulo 2^32) into a four-entry queue. The divider
// behind it picks up a period and forms the quotient rpm_scale / period
// (one bit a cycle); it takes no new period until its result has been
// popped with rsp_pop. A zero period skips the divide and returns valid_res
// low with rpm all ones. full rises only when four periods wait.
// Write csr_write_data (rpm_scale, reset 15000000) only while the block is idle.
// ----------------------------------------------------------------------------
module capture_period_rpm_meter_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic                           req_edge_req,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [cprm_pkg::DATA_BITS-1:0] rsp_period_ticks,
   output logic [cprm_pkg::DATA_BITS-1:0] rsp_rpm,
   output logic                           rsp_valid_res,
   input  logic                           csr_write_en,
   input  logic [cprm_pkg::DATA_BITS-1:0] csr_write_data
);
   import cprm_pkg::*;

   queue_status_type     q_status;
   logic                 tick_accept;
   logic                 q_write;
   logic [DATA_BITS-1:0] q_wr_period;
   logic                 q_read;
   logic [DATA_BITS-1:0] q_rd_period;

   assign req_full    = q_status.full;
   assign tick_accept = req_push & ~q_status.full;

   cprm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .tick_accept (tick_accept),
      .edge_req    (req_edge_req),
      .q_write     (q_write),
      .q_period    (q_wr_period)
   );

   cprm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_write),
      .wr_data (q_wr_period),
      .rd_en   (q_read),
      .rd_data (q_rd_period),
      .status  (q_status)
   );

   cprm_divider u_divider (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .q_status         (q_status),
      .q_period         (q_rd_period),
      .q_read           (q_read),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_period_ticks (rsp_period_ticks),
      .rsp_rpm          (rsp_rpm),
      .rsp_valid_res    (rsp_valid_res)
   );

endmodule
